@@ sv/battery_endpoint_decider_assert.svh @@
// ---------------------------------------------------------------------------
// battery_endpoint_decider assertion macros
// concurrent checks on clock, disabled while reset is high
// ---------------------------------------------------------------------------
`ifndef BATTERY_ENDPOINT_DECIDER_ASSERT_SVH
`define BATTERY_ENDPOINT_DECIDER_ASSERT_SVH

// condition holds at every edge out of reset
`define BED_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// same-cycle implication
`define BED_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BED_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/bed_pkg.sv @@
// ---------------------------------------------------------------------------
// bed_pkg
// types and kind codes shared by the battery endpoint decider
// ---------------------------------------------------------------------------
`default_nettype none

package bed_pkg;

   localparam int KIND_W = 3;

   localparam logic [KIND_W-1:0] KIND_NONE      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NATURAL   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EMERGENCY = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LOAD_SAG  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CAP_PEND  = 3'd4;

   typedef struct packed {
      logic charge_recovery;
      logic power_is_off;
      logic shutdown_is_armed;
      logic capacity_has_charge;
      logic capacity_exhausted;
      logic in_call;
      logic level_empty;
      logic level_low;
      logic modem_rail_collapse;
      logic sample_ok;
      logic floor_confirmed;
   } bed_req_type;

   typedef struct packed {
      logic [KIND_W-1:0] endpoint_kind;
      logic              do_shutdown;
      logic              mark_empty;
      logic              low_alert;
      logic              disagreement;
   } bed_rsp_type;

   typedef struct packed {
      logic              sag_latched;
      logic [KIND_W-1:0] armed_endpoint;
   } bed_state_type;

endpackage

`default_nettype wire

@@ sv/battery_endpoint_decider.sv @@
// ---------------------------------------------------------------------------
// battery_endpoint_decider
// turns gauge, charger and call status flags into a battery endpoint decision
// ---------------------------------------------------------------------------
//   channel   direction  payload        handshake
//   req_      in         bed_req_type   req_valid / req_ready
//   rsp_      out        bed_rsp_type   rsp_valid / rsp_ready
//
// one item per cycle sustained while rsp_ready stays high; rsp_valid rises once an accepted item
// has passed the input register, then decision logic into the result register
// the sag latch and armed kind update when an item moves into the result register
// a stalled result holds; the input register takes an item when it is empty
// or when its item moves on into a result register that drains or is empty
// synchronous reset clears valids, sag latch and armed kind
// ---------------------------------------------------------------------------
`default_nettype none

`include "battery_endpoint_decider_assert.svh"

module battery_endpoint_decider
   import bed_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire bed_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output bed_rsp_type      rsp_data
);

   logic          in_vld_ff, in_vld_in;
   bed_req_type   in_item_ff;
   logic          out_vld_ff, out_vld_in;
   bed_rsp_type   out_data_ff;
   bed_state_type state_ff, state_in;
   bed_state_type dec_state;
   bed_rsp_type   dec_result;
   logic          advance;

   bed_decide u_decide (
      .item      (in_item_ff),
      .cur_state (state_ff),
      .result    (dec_result),
      .nxt_state (dec_state)
   );

   assign advance   = in_vld_ff & (~out_vld_ff | rsp_ready);
   assign req_ready = ~in_vld_ff | advance;

   always_comb begin
      in_vld_in  = in_vld_ff;
      out_vld_in = out_vld_ff;
      state_in   = state_ff;
      if (advance) begin
         in_vld_in  = 1'b0;
         out_vld_in = 1'b1;
         state_in   = dec_state;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
      if (req_valid & req_ready) begin
         in_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         state_ff   <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= dec_result;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   `BED_ASSERT_ALWAYS(a_armed_kind_range,
      state_ff.armed_endpoint == KIND_NONE || state_ff.armed_endpoint == KIND_NATURAL ||
      state_ff.armed_endpoint == KIND_EMERGENCY,
      "armed endpoint holds a kind that never arms")
   `BED_ASSERT_IMPL(a_shutdown_kind,
      rsp_valid && rsp_data.do_shutdown,
      rsp_data.endpoint_kind == KIND_NATURAL || rsp_data.endpoint_kind == KIND_EMERGENCY,
      "shutdown result with a kind that is not natural or emergency")
   `BED_ASSERT_IMPL(a_learn_natural,
      rsp_valid && rsp_data.mark_empty,
      rsp_data.do_shutdown && rsp_data.endpoint_kind == KIND_NATURAL,
      "mark-empty without a natural shutdown")
   `BED_ASSERT_NEXT(a_clear_state,
      advance && (in_item_ff.charge_recovery || in_item_ff.power_is_off),
      state_ff == '0 && rsp_data == '0,
      "clearing item left state or result nonzero")
   `BED_ASSERT_NEXT(a_state_hold,
      !advance,
      $stable(state_ff),
      "state changed with no item moving to the result register")

endmodule

`default_nettype wire

@@ sv/bed_decide.sv @@
// ---------------------------------------------------------------------------
// bed_decide
// decision logic for one evidence item: endpoint kind, flags, next state
// ---------------------------------------------------------------------------
`default_nettype none

module bed_decide
   import bed_pkg::*;
(
   input  wire bed_req_type   item,
   input  wire bed_state_type cur_state,
   output bed_rsp_type        result,
   output bed_state_type      nxt_state
);

   logic trusted;
   logic live_sag;
   logic sag_upd;
   logic held_sag;
   logic any_sag;
   logic dis;
   logic gauge_end;
   logic cap_end;
   logic floor_end;
   logic coll_end;

   assign trusted  = item.capacity_has_charge & ~item.capacity_exhausted;
   assign live_sag = trusted & ((item.in_call & item.level_empty) | item.modem_rail_collapse);

   // latch sets on a live sag, clears on a clean healthy sample
   assign sag_upd = live_sag ? 1'b1 :
                    (item.sample_ok & ~item.level_empty & ~item.modem_rail_collapse) ? 1'b0 :
                    cur_state.sag_latched;

   assign held_sag = trusted & item.level_empty & (item.in_call | sag_upd);
   assign any_sag  = live_sag | held_sag;

   assign dis = item.capacity_exhausted & item.sample_ok & ~item.level_low &
                ~item.level_empty & ~item.floor_confirmed & ~item.modem_rail_collapse;

   assign gauge_end = item.sample_ok & item.level_empty & ~held_sag;
   assign cap_end   = item.capacity_exhausted & item.sample_ok & item.level_low &
                      ~item.level_empty & ~item.in_call;
   assign floor_end = item.floor_confirmed & (~item.in_call | ~trusted);
   assign coll_end  = item.modem_rail_collapse & ~trusted;

   always_comb begin
      result                = '0;
      nxt_state             = cur_state;
      nxt_state.sag_latched = sag_upd;
      if (item.charge_recovery | item.power_is_off) begin
         nxt_state = '0;
      end else if (item.shutdown_is_armed) begin
         nxt_state            = cur_state;
         result.endpoint_kind = (cur_state.armed_endpoint != KIND_NONE) ?
                                cur_state.armed_endpoint : KIND_EMERGENCY;
         result.do_shutdown   = 1'b1;
      end else if (gauge_end | cap_end | floor_end | coll_end) begin
         nxt_state.armed_endpoint = KIND_NATURAL;
         result.endpoint_kind     = KIND_NATURAL;
         result.do_shutdown       = 1'b1;
         result.mark_empty        = 1'b1;
         result.disagreement      = dis;
      end else if (item.floor_confirmed) begin
         nxt_state.armed_endpoint = KIND_EMERGENCY;
         result.endpoint_kind     = KIND_EMERGENCY;
         result.do_shutdown       = 1'b1;
         result.disagreement      = dis;
      end else if (any_sag) begin
         result.endpoint_kind = KIND_LOAD_SAG;
         result.low_alert     = 1'b1;
         result.disagreement  = dis;
      end else if (item.capacity_exhausted) begin
         result.endpoint_kind = KIND_CAP_PEND;
         result.low_alert     = 1'b1;
         result.disagreement  = dis;
      end else begin
         result.endpoint_kind = KIND_NONE;
         result.low_alert     = item.level_low;
         result.disagreement  = dis;
      end
   end

endmodule

`default_nettype wire

@@ test/tb_battery_endpoint_decider.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_battery_endpoint_decider
// drives evidence items through the decider under random sender gaps and
// receiver stalls, predicts every decision with its own copy of the sag latch
// and armed kind, and checks each result field in order of acceptance
// ---------------------------------------------------------------------------

module tb_battery_endpoint_decider;
   import bed_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   bed_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   bed_rsp_type rsp_data;

   // predictor state
   logic              sag_held = 1'b0;
   logic [KIND_W-1:0] kind_armed = KIND_NONE;

   bed_rsp_type decision_q[$];
   int          items_sent = 0;
   int          items_checked = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   bit          pace_gaps = 1'b1;

   battery_endpoint_decider dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit chance(input int unsigned pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // mostly short, now and then long
   function automatic int unsigned idle_span();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      else if (r < 96) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic bed_rsp_type predict_decision(input bed_req_type ev);
      bed_rsp_type d;
      logic trusted, live_sag, held_sag, any_sag;
      logic gauge_end, cap_end, floor_end, collapse_end;
      d = '0;
      if (ev.charge_recovery || ev.power_is_off) begin
         sag_held   = 1'b0;
         kind_armed = KIND_NONE;
         return d;
      end
      if (ev.shutdown_is_armed) begin
         d.endpoint_kind = (kind_armed != KIND_NONE) ? kind_armed : KIND_EMERGENCY;
         d.do_shutdown   = 1'b1;
         return d;
      end
      trusted  = ev.capacity_has_charge && !ev.capacity_exhausted;
      live_sag = trusted && ((ev.in_call && ev.level_empty) || ev.modem_rail_collapse);
      if (live_sag)
         sag_held = 1'b1;
      else if (ev.sample_ok && !ev.level_empty && !ev.modem_rail_collapse)
         sag_held = 1'b0;
      // the held sag sees the latch after this item's update
      held_sag = trusted && ev.level_empty && (ev.in_call || sag_held);
      any_sag  = live_sag || held_sag;

      d.disagreement = ev.capacity_exhausted && ev.sample_ok && !ev.level_low &&
                       !ev.level_empty && !ev.floor_confirmed && !ev.modem_rail_collapse;

      gauge_end    = ev.sample_ok && ev.level_empty && !held_sag;
      cap_end      = ev.capacity_exhausted && ev.sample_ok && ev.level_low &&
                     !ev.level_empty && !ev.in_call;
      floor_end    = ev.floor_confirmed && (!ev.in_call || !trusted);
      collapse_end = ev.modem_rail_collapse && !trusted;

      if (gauge_end || cap_end || floor_end || collapse_end) begin
         kind_armed      = KIND_NATURAL;
         d.endpoint_kind = KIND_NATURAL;
         d.do_shutdown   = 1'b1;
         d.mark_empty    = 1'b1;
      end else if (ev.floor_confirmed) begin
         kind_armed      = KIND_EMERGENCY;
         d.endpoint_kind = KIND_EMERGENCY;
         d.do_shutdown   = 1'b1;
      end else if (any_sag) begin
         d.endpoint_kind = KIND_LOAD_SAG;
         d.low_alert     = 1'b1;
      end else if (ev.capacity_exhausted) begin
         d.endpoint_kind = KIND_CAP_PEND;
         d.low_alert     = 1'b1;
      end else begin
         d.endpoint_kind = KIND_NONE;
         d.low_alert     = ev.level_low;
      end
      return d;
   endfunction

   task automatic check_field(input string field, input logic [2:0] want,
                              input logic [2:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   // accepted items are predicted before results are compared, in one process
   always @(posedge clock) begin
      bed_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            decision_q.push_back(predict_decision(req_data));
         if (rsp_valid && rsp_ready) begin
            if (decision_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
            end else begin
               want = decision_q.pop_front();
               check_field("endpoint_kind", want.endpoint_kind, rsp_data.endpoint_kind);
               check_field("do_shutdown", 3'(want.do_shutdown), 3'(rsp_data.do_shutdown));
               check_field("mark_empty", 3'(want.mark_empty), 3'(rsp_data.mark_empty));
               check_field("low_alert", 3'(want.low_alert), 3'(rsp_data.low_alert));
               check_field("disagreement", 3'(want.disagreement),
                           3'(rsp_data.disagreement));
               items_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: ready runs broken by stalls, with the odd long stall-free stretch
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         rsp_ready <= 1'b1;
         repeat (chance(5) ? $urandom_range(100, 200) : $urandom_range(1, 30))
            @(posedge clock);
         rsp_ready <= 1'b0;
         repeat (idle_span() - 1) @(posedge clock);
      end
   end

   task automatic send_evidence(input bed_req_type ev);
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (pace_gaps && chance(40)) begin
         req_valid <= 1'b0;
         req_data  <= bed_req_type'(11'($urandom_range(0, 2047)));
         repeat (idle_span()) @(posedge clock);
      end
   endtask

   function automatic bed_req_type random_evidence();
      bed_req_type ev;
      ev = '0;
      ev.capacity_has_charge = chance(75);
      ev.capacity_exhausted  = chance(30);
      ev.in_call             = chance(40);
      ev.level_empty         = chance(40);
      ev.level_low           = chance(40);
      ev.modem_rail_collapse = chance(20);
      ev.sample_ok           = chance(75);
      ev.floor_confirmed     = chance(15);
      return ev;
   endfunction

   task automatic test_directed_endpoints();
      bed_req_type ev;
      ev = '0; send_evidence(ev);
      ev = '0; ev.level_low = 1'b1; send_evidence(ev);
      // armed with nothing stored falls back to emergency
      ev = '0; ev.shutdown_is_armed = 1'b1; send_evidence(ev);
      // sag under call latches, then holds without the call
      ev = '0; ev.capacity_has_charge = 1'b1; ev.in_call = 1'b1;
      ev.level_empty = 1'b1; ev.sample_ok = 1'b1; send_evidence(ev);
      ev.in_call = 1'b0; send_evidence(ev);
      ev.level_empty = 1'b0; send_evidence(ev);
      // latch now cleared, so empty is a natural endpoint
      ev.level_empty = 1'b1; send_evidence(ev);
      ev = '0; ev.shutdown_is_armed = 1'b1; send_evidence(ev);
      ev = '0; ev.charge_recovery = 1'b1; send_evidence(ev);
      ev = '0; ev.capacity_exhausted = 1'b1; ev.sample_ok = 1'b1; send_evidence(ev);
      ev.level_low = 1'b1; send_evidence(ev);
      ev = '0; ev.power_is_off = 1'b1; send_evidence(ev);
      // floor breach under trusted call is an emergency
      ev = '0; ev.floor_confirmed = 1'b1; ev.in_call = 1'b1;
      ev.capacity_has_charge = 1'b1; send_evidence(ev);
      ev = '0; ev.shutdown_is_armed = 1'b1; send_evidence(ev);
      ev = '1; send_evidence(ev);
      ev = '0; ev.modem_rail_collapse = 1'b1; send_evidence(ev);
      ev = '0; ev.power_is_off = 1'b1; ev.shutdown_is_armed = 1'b1; send_evidence(ev);
      ev = '0; ev.modem_rail_collapse = 1'b1; ev.capacity_has_charge = 1'b1;
      send_evidence(ev);
      ev = '0; ev.capacity_exhausted = 1'b1; send_evidence(ev);
      ev = '0; ev.capacity_exhausted = 1'b1; ev.sample_ok = 1'b1;
      ev.floor_confirmed = 1'b1; send_evidence(ev);
      ev = '1; ev.charge_recovery = 1'b0; ev.power_is_off = 1'b0; send_evidence(ev);
      ev = '0; ev.charge_recovery = 1'b1; send_evidence(ev);
   endtask

   // clear, a run of evidence, then a few armed repeats
   task automatic test_random_sessions();
      bed_req_type ev;
      int          target;
      target = items_sent + 700;
      while (items_sent < target) begin
         if ((items_sent % 50) < 3) pace_gaps = chance(70);
         ev = '0;
         if (chance(50)) ev.charge_recovery = 1'b1;
         else ev.power_is_off = 1'b1;
         if (chance(10)) begin
            ev.charge_recovery = 1'b1;
            ev.power_is_off    = 1'b1;
         end
         send_evidence(ev);
         repeat ($urandom_range(3, 15)) send_evidence(random_evidence());
         repeat ($urandom_range(0, 3)) begin
            ev = random_evidence();
            ev.shutdown_is_armed = 1'b1;
            send_evidence(ev);
         end
      end
   endtask

   task automatic test_random_noise();
      repeat (300) begin
         if (chance(3)) pace_gaps = !pace_gaps;
         send_evidence(bed_req_type'(11'($urandom_range(0, 2047))));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_endpoints();
      test_random_sessions();
      test_random_noise();
      req_valid <= 1'b0;
      while (items_checked != items_sent) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
